FILE: design/tlpt_pkg.sv
`default_nettype none

package tlpt_pkg;

  // Request codes
  localparam logic [2:0] REQ_MAP    = 3'd0;
  localparam logic [2:0] REQ_UNMAP  = 3'd1;
  localparam logic [2:0] REQ_LOOKUP = 3'd2;
  localparam logic [2:0] REQ_MARK   = 3'd3;
  localparam logic [2:0] REQ_FAULT  = 3'd4;

  // Result status
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ALREADY    = 3'd1,
    ST_NOT_MAPPED = 3'd2,
    ST_NO_SLOT    = 3'd3,
    ST_FAULT      = 3'd4
  } status_t;

  // Page entry as stored in the page memory
  typedef struct packed {
    logic [19:0] frame;
    logic [1:0]  cow;       // bit0 copy-on-write, bit1 originally writable
    logic        user;
    logic        writable;
    logic        present;
  } pte_t;

  // 10-bit index fields; a table of at least 16 entries needs at most
  // six conditional subtractions to bring a 10-bit index into range
  localparam int IDX_W      = 10;
  localparam int WRAP_STEPS = 6;

  // Restoring reduction of a 10-bit index modulo d (d >= 16)
  function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W:0] d);
    logic [16:0] r;
    logic [16:0] dd;
    r = {7'b0, x};
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      dd = {6'b0, d} << k;
      if (r >= dd) begin
        r = r - dd;
      end
    end
    return r[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/tlpt_if.sv
`default_nettype none

// Request channel
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [19:0] virt_page;
  logic [19:0] phys_frame;
  logic        user_flag;
  logic        write_flag;
  logic        present_flag;

  modport source (output valid, output req_type, output virt_page, output phys_frame,
                  output user_flag, output write_flag, output present_flag,
                  input ready);
  modport sink (input valid, input req_type, input virt_page, input phys_frame,
                input user_flag, input write_flag, input present_flag,
                output ready);
endinterface

// Response channel
interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_present;
  logic [19:0] frame_out;
  logic        page_user;
  logic        page_writable;
  logic [1:0]  cow_bits;

  modport source (output valid, output status, output is_present, output frame_out,
                  output page_user, output page_writable, output cow_bits,
                  input ready);
  modport sink (input valid, input status, input is_present, input frame_out,
                input page_user, input page_writable, input cow_bits,
                output ready);
endinterface

`default_nettype wire

FILE: design/tlpt_store.sv
`default_nettype none

// Single-port-write, single-port-read synchronous memory with a zeroing
// pass after reset. busy stays high until every entry has been cleared.
module tlpt_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  output logic                          busy
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    cnt;

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Memory array: clear sweep has priority over functional writes
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_sweep_full: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(cnt) == AW'(DEPTH - 1))
    else $error("clear sweep ended early");
  a_no_wr_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("write during clear sweep");
  a_no_rd_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !rd_en)
    else $error("read during clear sweep");
`endif

endmodule

`default_nettype wire

FILE: design/two_level_page_table_cow_engine_top.sv
`default_nettype none

// Two-level page table engine with copy-on-write. Each request (map, unmap,
// lookup, mark copy-on-write, write fault) on the req channel gives exactly
// one response on rsp. A request passes through the transfer, the directory
// read, the dependent page entry read, then update/write-back into the
// result register; the two synchronous memory reads are chained, and one
// request is in flight at a time. A result waiting on rsp does not block
// the next transfer on req, but that request's update step waits until the
// earlier result has been taken. After reset both memories are zeroed, one
// entry a cycle, and req.ready stays low until both zeroing passes are done.
// Table slots are handed out in order and never reclaimed.
module two_level_page_table_cow_engine_top
  import tlpt_pkg::*;
#(
  parameter int DIR_ENTRIES   = 1024,
  parameter int TABLE_ENTRIES = 1024,
  parameter int TABLE_SLOTS   = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  tlpt_req_if.sink   req,
  tlpt_rsp_if.source rsp
);

  localparam int DI_W       = $clog2(DIR_ENTRIES);
  localparam int TI_W       = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int NF_W       = $clog2(TABLE_SLOTS + 1);
  localparam int PAGE_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
  localparam int PA_W       = $clog2(PAGE_DEPTH);
  localparam int DIR_W      = SLOT_W + 1;
  localparam int PTE_W      = $bits(pte_t);

  typedef enum logic [1:0] {S_IDLE, S_DIR, S_PAGE, S_EXEC} state_t;

  state_t          state;

  // Captured request
  logic [2:0]      rq_type;
  logic [19:0]     rq_vp;
  logic [19:0]     rq_frame;
  logic            rq_user;
  logic            rq_wr;
  logic            rq_pres;

  logic [DI_W-1:0] di_r;
  logic [TI_W-1:0] ti_r;
  logic            dvalid_r;
  logic            use_mem_r;
  logic            no_slot_r;
  logic [PA_W-1:0] pidx_r;
  logic [NF_W-1:0] next_free;

  // Result register
  logic            out_valid;
  status_t         out_status;
  pte_t            out_pte;

  // Memory hookup
  logic [DIR_W-1:0] dir_q;
  logic [PTE_W-1:0] page_q;
  logic             dir_busy;
  logic             page_busy;

  logic [DI_W-1:0]   di_c;
  logic [TI_W-1:0]   ti_c;
  logic              dvalid_c;
  logic [SLOT_W-1:0] slot_c;
  logic              alloc_c;
  logic              no_slot_c;
  logic [SLOT_W-1:0] slot_use;
  logic [PA_W-1:0]   pidx_c;

  logic    exec_fire;
  pte_t    e;
  pte_t    ne;
  logic    pwr_c;
  status_t st_c;
  pte_t    res_c;

  // Index wrap, directory decode and slot allocation
  always_comb begin
    di_c      = DI_W'(wrap_index(rq_vp[19:10], (IDX_W + 1)'(DIR_ENTRIES)));
    ti_c      = TI_W'(wrap_index(rq_vp[9:0], (IDX_W + 1)'(TABLE_ENTRIES)));
    dvalid_c  = dir_q[SLOT_W];
    slot_c    = dir_q[SLOT_W-1:0];
    alloc_c   = (rq_type == REQ_MAP) && !dvalid_c && (next_free < NF_W'(TABLE_SLOTS));
    no_slot_c = (rq_type == REQ_MAP) && !dvalid_c && !(next_free < NF_W'(TABLE_SLOTS));
    slot_use  = alloc_c ? SLOT_W'(next_free) : slot_c;
    pidx_c    = PA_W'(slot_use) * PA_W'(TABLE_ENTRIES) + PA_W'(ti_r);
  end

  // Entry update and result
  always_comb begin
    e     = use_mem_r ? pte_t'(page_q) : '0;
    ne    = e;
    pwr_c = 1'b0;
    st_c  = ST_OK;
    res_c = e;
    if (no_slot_r) begin
      st_c  = ST_NO_SLOT;
      res_c = '0;
    end else begin
      unique case (rq_type)
        REQ_MAP: begin
          if (e.present) begin
            st_c = ST_ALREADY;
          end else begin
            ne          = '0;
            ne.present  = 1'b1;
            ne.user     = rq_user;
            ne.writable = rq_wr;
            ne.frame    = rq_frame;
            pwr_c       = 1'b1;
            res_c       = ne;
          end
        end
        REQ_UNMAP: begin
          if (!e.present) begin
            st_c = ST_NOT_MAPPED;
          end else begin
            ne    = '0;
            pwr_c = 1'b1;
            res_c = ne;
          end
        end
        REQ_LOOKUP: begin
          st_c = e.present ? ST_OK : ST_NOT_MAPPED;
        end
        REQ_MARK: begin
          if (!e.present) begin
            st_c = ST_NOT_MAPPED;
          end else begin
            ne.cow      = {e.writable, 1'b1};
            ne.writable = 1'b0;
            pwr_c       = 1'b1;
            res_c       = ne;
          end
        end
        REQ_FAULT: begin
          if (rq_user && rq_wr && rq_pres && dvalid_r && (e.cow != 2'b00)) begin
            ne.cow      = 2'b00;
            ne.frame    = rq_frame;
            ne.writable = 1'b1;
            pwr_c       = 1'b1;
            res_c       = ne;
          end else begin
            st_c = ST_FAULT;
          end
        end
        default: begin
          res_c = '0;
        end
      endcase
    end
  end

  assign exec_fire = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign req.ready = (state == S_IDLE) && !dir_busy && !page_busy;

  // Sequencer, request capture and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_free <= '0;
      out_valid <= 1'b0;
    end else begin
      // New result replaces one that transfers in the same cycle
      if (exec_fire) begin
        out_valid  <= 1'b1;
        out_status <= st_c;
        out_pte    <= res_c;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            rq_type  <= req.req_type;
            rq_vp    <= req.virt_page;
            rq_frame <= req.phys_frame;
            rq_user  <= req.user_flag;
            rq_wr    <= req.write_flag;
            rq_pres  <= req.present_flag;
            state    <= S_DIR;
          end
        end
        S_DIR: begin
          di_r  <= di_c;
          ti_r  <= ti_c;
          state <= S_PAGE;
        end
        S_PAGE: begin
          dvalid_r  <= dvalid_c;
          use_mem_r <= dvalid_c || alloc_c;
          no_slot_r <= no_slot_c;
          pidx_r    <= pidx_c;
          if (alloc_c) begin
            next_free <= next_free + 1'b1;
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Directory memory: valid bit over slot number
  tlpt_store #(
    .DEPTH (DIR_ENTRIES),
    .WIDTH (DIR_W)
  ) u_dir (
    .clk     (clk),
    .rst     (rst),
    .wr_en   ((state == S_PAGE) && alloc_c),
    .wr_addr (di_r),
    .wr_data ({1'b1, slot_use}),
    .rd_en   (state == S_DIR),
    .rd_addr (di_c),
    .rd_data (dir_q),
    .busy    (dir_busy)
  );

  // Page entry memory, TABLE_ENTRIES entries per slot
  tlpt_store #(
    .DEPTH (PAGE_DEPTH),
    .WIDTH (PTE_W)
  ) u_page (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (exec_fire && pwr_c),
    .wr_addr (pidx_r),
    .wr_data (ne),
    .rd_en   (state == S_PAGE),
    .rd_addr (pidx_c),
    .rd_data (page_q),
    .busy    (page_busy)
  );

  // Response payload
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.is_present    = out_pte.present;
  assign rsp.frame_out     = out_pte.frame;
  assign rsp.page_user     = out_pte.user;
  assign rsp.page_writable = out_pte.writable;
  assign rsp.cow_bits      = out_pte.cow;

`ifndef SYNTHESIS
  a_accept_to_dir: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == S_DIR)
    else $error("transfer did not start a directory read");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NF_W'(TABLE_SLOTS))
    else $error("slot allocator overran");
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_EXEC)
    else $error("result appeared outside the update step");
  a_no_slot_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_NO_SLOT) |-> !rsp.is_present && rsp.frame_out == '0)
    else $error("no-slot result carries an entry");
`endif

endmodule

`default_nettype wire
